// File: hw/rtl/crsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_pkg: shared types and constants for the circle row span finder
// Coordinate width, walk variable types and sequencer state codes.
// ----------------------------------------------------------------------------
package crsf_pkg;

	localparam int CoordBits = 16;

	// coordinate as seen on the ports
	typedef logic [CoordBits-1:0] coord_t;
	// row sums that may carry past the grid
	typedef logic [CoordBits:0] row_t;
	// octant walk offsets, signed so b may step below zero
	typedef logic signed [CoordBits+1:0] pos_t;
	// decision variable, bounded by about four times the radius
	typedef logic signed [CoordBits+3:0] dec_t;

	// sequencer states
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StDone = 2'd2;

endpackage

// File: hw/rtl/circle_row_span_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_row_span_finder: row span of a midpoint circle
// Walks one octant of the midpoint circle and returns the span on a query row.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries center_x, center_y, radius and query_row on in_valid.
//   It is taken at a clock edge with in_valid high and in_stall low. in_stall
//   stays high from that edge until the result has been taken.
//   The result (hit, right_x, left_x) shows on out_valid and is taken at an
//   edge with out_valid high and out_stall low; it holds while out_stall is high.
//   The walk takes octant steps until one matches a mirrored row or a passes b;
//   the result is registered on that step and held in StDone. The walk step
//   (four row compares and one decision add) is a single unit reused once per
//   cycle, so one request is in flight at a time.
//   A miss reads hit 0, right_x 0 and left_x all ones.
//   Reset (arst_n low) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
module circle_row_span_finder
	import crsf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_stall,
	input  coord_t center_x,
	input  coord_t center_y,
	input  coord_t radius,
	input  coord_t query_row,
	output logic   out_valid,
	input  logic   out_stall,
	output logic   hit,
	output coord_t right_x,
	output coord_t left_x
);

	logic [1:0] state_q;
	coord_t     cx_q;
	coord_t     cy_q;
	coord_t     row_q;
	pos_t       a_q;
	pos_t       b_q;
	dec_t       d_q;
	logic       hit_q;
	coord_t     right_q;
	coord_t     left_q;

	logic       in_take;
	logic       out_take;
	logic       walk_end;
	coord_t     a_lo;
	coord_t     b_lo;
	logic       m_top;
	logic       m_mid;
	logic       m_bot;
	pos_t       a_nxt;
	dec_t       d_nxt;
	pos_t       b_nxt;

	assign in_take  = in_valid && !in_stall;
	assign out_take = out_valid && !out_stall;
	assign in_stall  = (state_q != StIdle);
	assign out_valid = (state_q == StDone);
	assign hit     = hit_q;
	assign right_x = right_q;
	assign left_x  = left_q;

	// loop ends once a passes b
	assign walk_end = (a_q > b_q);
	assign a_lo = a_q[CoordBits-1:0];
	assign b_lo = b_q[CoordBits-1:0];

	// mirrored row compares, exact over one extra bit
	assign m_top = ({1'b0, cy_q} == ({1'b0, row_q} + {1'b0, b_lo}));
	assign m_mid = ({1'b0, cy_q} == ({1'b0, row_q} + {1'b0, a_lo}))
		|| ({1'b0, row_q} == ({1'b0, cy_q} + {1'b0, a_lo}));
	assign m_bot = ({1'b0, row_q} == ({1'b0, cy_q} + {1'b0, b_lo}));

	// decision update for the next step
	always_comb begin
		a_nxt = a_q + pos_t'(1);
		b_nxt = b_q;
		if (d_q < 0) begin
			d_nxt = d_q + (dec_t'(a_nxt) <<< 2) + dec_t'(6);
		end else begin
			d_nxt = d_q + dec_t'(10) + (dec_t'(a_nxt - b_q) <<< 2);
			b_nxt = b_q - pos_t'(1);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (in_take) state_q <= StRun;
				end
				StRun: begin
					if (walk_end || m_top || m_mid || m_bot) state_q <= StDone;
				end
				StDone: begin
					if (out_take) state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// walk registers and result
	always_ff @(posedge clk) begin
		if (in_take) begin
			cx_q  <= center_x;
			cy_q  <= center_y;
			row_q <= query_row;
			a_q   <= '0;
			b_q   <= pos_t'(radius);
			d_q   <= dec_t'(3) - (dec_t'(radius) <<< 1);
		end else if (state_q == StRun) begin
			if (walk_end) begin
				hit_q   <= 1'b0;
				right_q <= '0;
				left_q  <= '1;
			end else if (m_top || (!m_mid && m_bot)) begin
				hit_q   <= 1'b1;
				right_q <= cx_q + a_lo;
				left_q  <= cx_q - a_lo;
			end else if (m_mid) begin
				hit_q   <= 1'b1;
				right_q <= cx_q + b_lo;
				left_q  <= cx_q - b_lo;
			end else begin
				a_q <= a_nxt;
				b_q <= b_nxt;
				d_q <= d_nxt;
			end
		end
	end

endmodule

// File: hw/rtl/crsf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_checker: port checks for the circle row span finder
// Watches the top level ports for ordering and result format.
// ----------------------------------------------------------------------------
module crsf_checker
	import crsf_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_stall,
	input logic   out_valid,
	input logic   out_stall,
	input logic   hit,
	input coord_t right_x,
	input coord_t left_x
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(right_x)
			&& $stable(left_x))
		else $error("stalled result changed");

	// a taken request keeps the input closed
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("input open right after a request");

	// no new request while a result waits
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while result pending");

	// a miss has the fixed span
	a_miss_format: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (right_x == '0) && (left_x == '1))
		else $error("miss span wrong");

endmodule

bind circle_row_span_finder crsf_checker u_crsf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.hit       (hit),
	.right_x   (right_x),
	.left_x    (left_x)
);

// File: dv/tb_circle_row_span_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_row_span_finder: self-checking bench for the circle row span finder
// Drives circle requests through the valid/stall handshake with random gaps on
// both sides and checks every span against a midpoint circle walk done here.
// ----------------------------------------------------------------------------
module tb_circle_row_span_finder;
	import crsf_pkg::*;

	typedef struct packed {
		logic   hit;
		coord_t right;
		coord_t left;
	} span_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t center_x = '0;
	coord_t center_y = '0;
	coord_t radius = '0;
	coord_t query_row = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   hit;
	coord_t right_x;
	coord_t left_x;

	span_t expected_spans[$];
	int    errors = 0;
	int    requests_sent = 0;
	int    hits_checked = 0;
	int    misses_checked = 0;
	bit    send_gaps_on = 1'b1;
	bit    stall_on = 1'b1;
	int    stall_left = 0;

	circle_row_span_finder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.query_row (query_row),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.right_x   (right_x),
		.left_x    (left_x)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 19) < 16)
			return $urandom_range(0, 3);
		return $urandom_range(20, 60);
	endfunction

	// midpoint circle octant walk, first matching mirrored row wins
	function automatic span_t predict_span(input coord_t cx, input coord_t cy,
			input coord_t r, input coord_t row);
		longint a;
		longint b;
		longint d;
		longint x;
		longint y;
		longint q;
		span_t  s;
		a = 0;
		b = r;
		d = 3 - 2 * longint'(r);
		x = cx;
		y = cy;
		q = row;
		s.hit = 1'b0;
		s.right = '0;
		s.left = '1;
		while (a <= b) begin
			if (y - b == q || y + b == q) begin
				s.hit = 1'b1;
				s.right = coord_t'(x + a);
				s.left = coord_t'(x - a);
				return s;
			end
			if (y - a == q || y + a == q) begin
				s.hit = 1'b1;
				s.right = coord_t'(x + b);
				s.left = coord_t'(x - b);
				return s;
			end
			a++;
			if (d < 0) begin
				d += 4 * a + 6;
			end else begin
				d += 10 + 4 * (a - b);
				b--;
			end
		end
		return s;
	endfunction

	// send one request, optionally waiting until the block has drained
	task automatic send_request(input coord_t cx, input coord_t cy, input coord_t r,
			input coord_t row, input bit drain_first = 1'b0);
		int gap;
		gap = send_gaps_on ? idle_len() : 0;
		if (gap != 0 || drain_first) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			if (drain_first) begin
				do @(posedge clk); while (expected_spans.size() != 0);
			end
		end
		in_valid <= 1'b1;
		center_x <= cx;
		center_y <= cy;
		radius <= r;
		query_row <= row;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_spans.push_back(predict_span(cx, cy, r, row));
		requests_sent++;
	endtask

	// result side stall pattern
	always @(posedge clk) begin
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (stall_on && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_left <= idle_len();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each taken result with the oldest pending span
	always @(posedge clk) begin : result_check
		span_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_spans.size() == 0) begin
				$error("result with no request pending: hit %0b right_x %0d left_x %0d",
					hit, right_x, left_x);
				errors++;
			end else begin
				want = expected_spans.pop_front();
				if (hit !== want.hit) begin
					$error("hit mismatch: expected %0b, got %0b", want.hit, hit);
					errors++;
				end
				if (right_x !== want.right) begin
					$error("right_x mismatch: expected %0d, got %0d", want.right, right_x);
					errors++;
				end
				if (left_x !== want.left) begin
					$error("left_x mismatch: expected %0d, got %0d", want.left, left_x);
					errors++;
				end
				if (want.hit)
					hits_checked++;
				else
					misses_checked++;
			end
		end
	end

	// corner cases: zero radius, tiny circles, wrapped spans, off-grid rows
	task automatic test_directed();
		send_request(16'd1234, 16'd500, 16'd0, 16'd500);
		send_request(16'd1234, 16'd500, 16'd0, 16'd501);
		send_request(16'd0, 16'd0, 16'd0, 16'd0);
		send_request(16'd0, 16'd0, 16'd0, 16'hffff);
		send_request(16'hffff, 16'hffff, 16'hffff, 16'hffff);
		send_request(16'd200, 16'd300, 16'd1, 16'd299);
		send_request(16'd200, 16'd300, 16'd1, 16'd300);
		send_request(16'd200, 16'd300, 16'd1, 16'd301);
		send_request(16'd200, 16'd300, 16'd1, 16'd302);
		send_request(16'd5000, 16'd4000, 16'd10, 16'd3990);
		send_request(16'd5000, 16'd4000, 16'd10, 16'd4010);
		send_request(16'd5000, 16'd4000, 16'd10, 16'd4007);
		send_request(16'd5000, 16'd4000, 16'd10, 16'd4011);
		// span wraps below zero and past the top
		send_request(16'd3, 16'd1000, 16'd10, 16'd1000);
		send_request(16'd65530, 16'd1000, 16'd20, 16'd1005);
		// mirrored rows below and above the grid must not match wrapped rows
		send_request(16'd100, 16'd5, 16'd10, 16'd65531);
		send_request(16'd100, 16'd65530, 16'd20, 16'd14);
		send_request(16'd400, 16'd30, 16'd100, 16'd0);
		// long walks: a miss and a match near the end of the octant
		send_request(16'd777, 16'd0, 16'd40000, 16'd50000);
		send_request(16'd32768, 16'd0, 16'd65535, 16'd46340);
	endtask

	// small circles, rows mostly around the circle, some anywhere
	task automatic test_random_small(input int count);
		coord_t cy;
		coord_t r;
		coord_t row;
		int     off;
		repeat (count) begin
			cy = coord_t'($urandom);
			r = ($urandom_range(0, 3) == 0) ? coord_t'($urandom_range(0, 8))
				: coord_t'($urandom_range(0, 200));
			if ($urandom_range(0, 9) == 0) begin
				row = coord_t'($urandom);
			end else begin
				off = $urandom_range(0, 2 * r + 6);
				row = coord_t'(int'(cy) - int'(r) - 3 + off);
			end
			send_request(coord_t'($urandom), cy, r, row);
		end
	endtask

	// full range radius with rows that end the walk early, plus misses just past a radius up to 4095
	task automatic test_random_wide(input int count);
		coord_t cy;
		coord_t r;
		coord_t row;
		repeat (count) begin
			r = coord_t'($urandom);
			case ($urandom_range(0, 3))
				0: begin
					cy = coord_t'($urandom_range(r, 65535));
					row = coord_t'(int'(cy) - int'(r) + $urandom_range(0, 4));
				end
				1: begin
					cy = coord_t'($urandom_range(0, 65535 - r));
					row = coord_t'(int'(cy) + int'(r) - $urandom_range(0, 4));
				end
				2: begin
					cy = coord_t'($urandom_range(300, 65235));
					row = ($urandom_range(0, 1) == 0)
						? coord_t'(int'(cy) + $urandom_range(0, 300))
						: coord_t'(int'(cy) - $urandom_range(0, 300));
				end
				default: begin
					r = coord_t'($urandom_range(0, 4095));
					cy = coord_t'($urandom);
					row = coord_t'(int'(cy) + int'(r) + 1 + $urandom_range(0, 2));
				end
			endcase
			send_request(coord_t'($urandom), cy, r, row);
		end
	endtask

	// back to back requests with no idling on either side
	task automatic test_back_to_back(input int count);
		send_gaps_on = 1'b0;
		stall_on = 1'b0;
		test_random_small(count);
		send_gaps_on = 1'b1;
		stall_on = 1'b1;
	endtask

	// sender holds off until every pending result has come back
	task automatic test_drained(input int count);
		coord_t cy;
		coord_t r;
		repeat (count) begin
			cy = coord_t'($urandom);
			r = coord_t'($urandom_range(0, 64));
			send_request(coord_t'($urandom), cy,
				r, coord_t'(int'(cy) + $urandom_range(0, 2 * r + 2) - int'(r) - 1), 1'b1);
		end
	endtask

	// reset, run the tests, drain and report
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_small(60);
		test_back_to_back(15);
		test_random_wide(15);
		test_drained(10);
		in_valid <= 1'b0;
		while (expected_spans.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d requests sent, %0d hits and %0d misses checked", requests_sent,
			hits_checked, misses_checked);
		$display("directed corners, small and full range radii, gaps, stalls, drains");
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run time limit
	initial begin
		#300000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
